FILE: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int FIELD_BITS   = 32;
    localparam int BIT_IDX_W    = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [BIT_IDX_W-1:0]    t_bit_idx;

    // request to the shared modular multiplier
    typedef struct packed {
        logic     start;
        t_operand a;
        t_operand b;
        t_operand m;
    } t_mm_req;

    // response from the shared modular multiplier
    typedef struct packed {
        logic     busy;
        logic     done;
        t_operand result;
    } t_mm_rsp;

endpackage

FILE: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by square-and-multiply.
//
// Usage:
//   cfg channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the modulus;
//   a modulus of zero acts as one. Write it only while the block is idle.
//   s_axis carries {exponent_value, base_value}; m_axis returns power_result.
//   One transaction in gives one transaction out, in order.
// Operation:
//   All products go through one bit-serial modular multiplier that works
//   through a product as start, one step per bit of b, and done. An item needs
//   33 + k products (base reduction, one square per exponent bit and one
//   multiply per one bit, k = number of one bits) before m_axis_tvalid
//   rises. Exponent zero skips the multiplier and returns 1. s_axis_tready
//   is high only while no item is in work, so a new input is not taken
//   before the last one is through; it can be taken in the cycle after the
//   result is loaded into the output register.
// Reset and stall:
//   Reset clears the sequencer and the output valid and sets the modulus
//   to 2. The result sits in an output register; while m_axis_tready is
//   low the next item is still accepted and computed, and it waits for the
//   output register to free up.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel: modulus
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [FIELD_BITS-1:0]   i_cfg_data,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [2*FIELD_BITS-1:0] s_axis_tdata,  // [31:0] base_value, [63:32] exponent_value
    // output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [FIELD_BITS-1:0]   m_axis_tdata   // [31:0] power_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]              r_state;
    logic                    r_wait;
    t_bit_idx                r_bit;
    t_operand                r_mod_cfg;
    t_operand                r_m;
    t_operand                r_exp;
    t_operand                r_base;
    t_operand                r_acc;
    logic                    r_out_valid;
    logic [FIELD_BITS-1:0]   r_out_data;

    t_mm_req                 mm_req;
    t_mm_rsp                 mm_rsp;
    logic                    in_fire;
    logic                    computing;
    logic                    out_free;
    t_operand                in_base;
    t_operand                in_exp;
    t_operand                eff_mod;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_base       = t_operand'(s_axis_tdata[FIELD_BITS-1:0]);
    assign in_exp        = t_operand'(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    assign eff_mod       = (r_mod_cfg == '0) ? t_operand'(1) : r_mod_cfg;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign computing     = (r_state == ST_REDUCE) || (r_state == ST_SQUARE) ||
                           (r_state == ST_MULT);

    // the accumulator always feeds port a; reduction multiplies (1 mod m) by the raw base
    assign mm_req.start = computing && !r_wait;
    assign mm_req.a     = r_acc;
    assign mm_req.b     = (r_state == ST_SQUARE) ? r_acc : r_base;
    assign mm_req.m     = r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cfg <= t_operand'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mod_cfg <= t_operand'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (mm_req.start) begin
                r_wait <= 1'b1;
            end else if (mm_rsp.done) begin
                r_wait <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= (in_exp == '0) ? ST_DONE : ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (mm_rsp.done) begin
                        r_state <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (mm_rsp.done) begin
                        if (r_exp[r_bit]) begin
                            r_state <= ST_MULT;
                        end else if (r_bit == '0) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_MULT: begin
                    if (mm_rsp.done) begin
                        r_state <= (r_bit == '0) ? ST_DONE : ST_SQUARE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_m    <= eff_mod;
                    r_exp  <= in_exp;
                    r_base <= in_base;
                    r_bit  <= t_bit_idx'(OPERAND_BITS - 1);
                    if (in_exp == '0) begin
                        r_acc <= t_operand'(1);
                    end else begin
                        r_acc <= (eff_mod == t_operand'(1)) ? '0 : t_operand'(1);
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_rsp.done) begin
                    r_base <= mm_rsp.result;
                end
            end
            ST_SQUARE: begin
                if (mm_rsp.done) begin
                    r_acc <= mm_rsp.result;
                    if (!r_exp[r_bit] && r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end
            ST_MULT: begin
                if (mm_rsp.done) begin
                    r_acc <= mm_rsp.result;
                    if (r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= FIELD_BITS'(r_acc);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_done_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_rsp.done |-> r_wait)
        else $error("multiplier finished with no product outstanding");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQUARE || r_state == ST_MULT) |-> (r_acc < r_m))
        else $error("accumulator not reduced below modulus");

    a_zero_exp_shortcut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_exp == '0) |=> (r_state == ST_DONE && r_acc == t_operand'(1)))
        else $error("exponent zero did not yield one");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_rsp.busy |-> !mm_req.start)
        else $error("new product requested while multiplier busy");
`endif

endmodule

FILE: hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: (a * b) mod m by add-and-double,
// one bit of b per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    logic     r_busy;
    logic     r_done;
    t_bit_idx r_cnt;
    t_operand r_acc;
    t_operand r_a;
    t_operand r_b;
    t_operand r_m;

    t_operand n_dbl;
    t_operand n_acc;

    // (x + y) mod m for x, y < m, never wider than the operand
    function automatic t_operand add_mod(input t_operand x, input t_operand y,
                                         input t_operand m);
        t_operand room;
        room = m - y;
        if (x >= room) begin
            return x - room;
        end
        return x + y;
    endfunction

    always_comb begin
        n_dbl = add_mod(r_acc, r_acc, r_m);
        n_acc = n_dbl;
        if (r_b[OPERAND_BITS-1]) begin
            n_acc = add_mod(n_dbl, r_a, r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_bit_idx'(OPERAND_BITS - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[OPERAND_BITS-2:0], 1'b0};
        end else if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule
